// ===== src/igmp_rb_pkg.sv =====
// Package for the IGMPv3 report builder: request codes, record types and the
// ones'-complement fold function. No dependencies.
package igmp_rb_pkg;

   localparam logic [1:0] FUNC_BEGIN  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [7:0] REPORT_TYPE  = 8'h22;
   localparam logic [7:0] TYPE_TO_EXCL = 8'h04;
   localparam logic [7:0] TYPE_TO_INCL = 8'h03;
   localparam logic [7:0] RESERVED     = 8'h00;

   // Add two 16-bit halves of a word into a 16-bit ones'-complement sum.
   function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [31:0] w);
      logic [17:0] s;
      logic [16:0] t;
      s = {2'b00, acc} + {2'b00, w[31:16]} + {2'b00, w[15:0]};
      t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

// ===== src/igmp_rb_csum.sv =====
// Checksum accumulator: folds one report word per cycle, while add is high, into a 16-bit
// ones'-complement sum. Depends on igmp_rb_pkg.
module igmp_rb_csum (
   input  logic        clock,
   input  logic        clear,
   input  logic        add,
   input  logic [31:0] word,
   output logic [15:0] sum
);
   logic [15:0] sum_ff, sum_in;

   // accumulate under sequencer control
   always_comb begin
      sum_in = sum_ff;
      if (clear) begin
         sum_in = 16'd0;
      end else if (add) begin
         sum_in = igmp_rb_pkg::csum_add(sum_ff, word);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;
endmodule

// ===== src/igmpv3_report_builder.sv =====
// IGMPv3 report builder top level: record table, source memory, compaction
// and report sequencer. Depends on igmp_rb_pkg and igmp_rb_csum.
//
// Usage: requests arrive on req_valid/req_ready with req_func selecting
// begin record, append source or tick. A request is taken in idle and
// executed the next cycle; begin, append and unused codes end there.
// A tick then compacts the table: it scans each record header, moves each
// source of a record that shifts down with a read and then a write, and
// ends with a closing step. If records remain it walks the report words
// twice, addressing and then handling each word: once to sum the checksum,
// once to load each word into the output register for rsp_valid/rsp_ready.
// A report holds at most 2 + MAX_RECORDS*(2+MAX_SOURCES) words.
// req_ready is low for the whole of a request; one request at a time, and
// it rises only after the last word has been taken.
// A stalled receiver holds the current word and the sequencer waits.
// Synchronous reset empties the table and clears the drop flag; the
// source memory is not cleared and needs no clearing pass.
// rsp_dropped carries the drop flag as it stood before the report.
module igmpv3_report_builder #(
   parameter int MAX_RECORDS = 4,
   parameter int MAX_SOURCES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_group_address,
   input  logic        req_record_mode,
   input  logic [3:0]  req_retransmit_count,
   input  logic [31:0] req_source_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_packet_word,
   output logic        rsp_last_word,
   output logic        rsp_dropped
);
   localparam int ENT_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int REC_W = $clog2(MAX_RECORDS + 1);
   localparam int CNT_W = (MAX_SOURCES > 0) ? $clog2(MAX_SOURCES + 1) : 1;
   localparam int SLOTS = (MAX_RECORDS * MAX_SOURCES > 0) ? MAX_RECORDS * MAX_SOURCES : 1;
   localparam int ADR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_CREC = 3'd2;
   localparam logic [2:0] ST_CSRC = 3'd3;
   localparam logic [2:0] ST_CWR  = 3'd4;
   localparam logic [2:0] ST_WALK = 3'd5;
   localparam logic [2:0] ST_WRD  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   // word phases during a walk
   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_REC  = 3'd2;
   localparam logic [2:0] PH_GRP  = 3'd3;
   localparam logic [2:0] PH_SRC  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [MAX_RECORDS-1:0] valid_ff, valid_in;
   logic        excl_ff  [MAX_RECORDS];
   logic [31:0] group_ff [MAX_RECORDS];
   logic [3:0]  count_ff [MAX_RECORDS];
   logic [CNT_W-1:0] stot_ff [MAX_RECORDS];
   logic [ENT_W-1:0] newest_ff, newest_in;
   logic        open_ff, open_in, drop_ff, drop_in;

   // latched request
   logic [1:0]  func_ff;
   logic [31:0] grp_ff, src_ff;
   logic        mode_ff;
   logic [3:0]  rc_ff;

   // compaction / walk pointers
   logic [REC_W-1:0] rd_ff, rd_in, kept_ff, kept_in, used_cnt, kept_dec;
   logic [CNT_W-1:0] sj_ff, sj_in;
   logic [2:0]  ph_ff, ph_in;
   logic        pass_ff, pass_in;

   // source memory
   logic [31:0] mem [SLOTS];
   logic        mem_we;
   logic [ADR_W-1:0] mem_wa, mem_ra;
   logic [31:0] mem_wd, rdata_ff;

   // output register
   logic [31:0] word_ff;
   logic        last_ff, ovalid_ff, odrop_ff;

   logic [15:0] csum;
   logic        cs_clear, cs_add, load;
   logic        ent_new, src_add, hdr_move;
   logic [31:0] w_word;
   logic        w_last;
   logic [ENT_W-1:0] rd_e, kept_e, used_e;

   function automatic logic [ADR_W-1:0] slot(input logic [REC_W-1:0] e,
                                            input logic [CNT_W-1:0] j);
      logic [31:0] a;
      a = 32'(e) * 32'(MAX_SOURCES) + 32'(j);
      return a[ADR_W-1:0];
   endfunction

   // number of valid entries (prefix)
   always_comb begin
      used_cnt = '0;
      for (int i = 0; i < MAX_RECORDS; i++) begin
         if (valid_ff[i]) used_cnt = REC_W'(i + 1);
      end
   end

   assign rd_e     = rd_ff[ENT_W-1:0];
   assign kept_e   = kept_ff[ENT_W-1:0];
   assign used_e   = used_cnt[ENT_W-1:0];
   assign kept_dec = kept_ff - REC_W'(1);
   assign mem_ra   = slot(rd_ff, sj_ff);

   // current report word during a walk
   always_comb begin
      unique case (ph_ff)
         PH_HDR0: w_word = {igmp_rb_pkg::REPORT_TYPE, igmp_rb_pkg::RESERVED,
                            pass_ff ? ~csum : 16'd0};
         PH_HDR1: w_word = {16'd0, 16'(kept_ff)};
         PH_REC:  w_word = {(excl_ff[rd_e] ? igmp_rb_pkg::TYPE_TO_EXCL :
                             igmp_rb_pkg::TYPE_TO_INCL), igmp_rb_pkg::RESERVED,
                            16'(stot_ff[rd_e])};
         PH_GRP:  w_word = group_ff[rd_e];
         default: w_word = rdata_ff;   // source word
      endcase
      w_last = (rd_ff + REC_W'(1) == kept_ff) &&
               ((ph_ff == PH_GRP && stot_ff[rd_e] == '0) ||
                (ph_ff == PH_SRC && sj_ff + CNT_W'(1) == stot_ff[rd_e]));
   end

   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      newest_in = newest_ff;
      open_in   = open_ff;
      drop_in   = drop_ff;
      rd_in     = rd_ff;
      kept_in   = kept_ff;
      sj_in     = sj_ff;
      ph_in     = ph_ff;
      pass_in   = pass_ff;
      ent_new   = 1'b0;
      src_add   = 1'b0;
      hdr_move  = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = slot(kept_ff, sj_ff);
      mem_wd    = rdata_ff;
      cs_clear  = 1'b0;
      cs_add    = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (func_ff)
               igmp_rb_pkg::FUNC_BEGIN: begin
                  if (used_cnt >= REC_W'(MAX_RECORDS)) begin
                     drop_in = 1'b1;
                     open_in = 1'b0;
                  end else begin
                     valid_in[used_e] = 1'b1;
                     newest_in = used_e;
                     open_in = 1'b1;
                     ent_new = 1'b1;
                  end
               end
               igmp_rb_pkg::FUNC_APPEND: begin
                  if (!open_ff || !valid_ff[newest_ff] ||
                      stot_ff[newest_ff] >= CNT_W'(MAX_SOURCES)) begin
                     drop_in = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = slot(REC_W'(newest_ff), stot_ff[newest_ff]);
                     mem_wd = src_ff;
                     src_add = 1'b1;
                  end
               end
               igmp_rb_pkg::FUNC_TICK: begin
                  if (open_ff && valid_ff[newest_ff] && count_ff[newest_ff] == 4'd0)
                     open_in = 1'b0;
                  rd_in = '0;
                  kept_in = '0;
                  state_in = ST_CREC;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         // compaction: one record header per cycle, pausing while a record's sources are moved
         ST_CREC: begin
            sj_in = '0;
            if (rd_ff >= used_cnt) begin
               for (int i = 0; i < MAX_RECORDS; i++)
                  valid_in[i] = (REC_W'(i) < kept_ff);
               if (open_ff) newest_in = (kept_ff != '0) ? kept_dec[ENT_W-1:0] : '0;
               if (kept_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ph_in = PH_HDR0;
                  pass_in = 1'b0;
                  rd_in = '0;
                  cs_clear = 1'b1;
                  state_in = ST_WALK;
               end
            end else if (count_ff[rd_e] == 4'd0) begin
               rd_in = rd_ff + REC_W'(1);
            end else if (kept_ff != rd_ff && stot_ff[rd_e] != '0) begin
               state_in = ST_CSRC;
            end else begin
               hdr_move = 1'b1;
               rd_in = rd_ff + REC_W'(1);
               kept_in = kept_ff + REC_W'(1);
            end
         end
         // read one source of the record being moved
         ST_CSRC: begin
            state_in = ST_CWR;
         end
         // write it to the lower record; the last one moves the header too
         ST_CWR: begin
            mem_we = 1'b1;
            sj_in = sj_ff + CNT_W'(1);
            if (sj_ff + CNT_W'(1) == stot_ff[rd_e]) begin
               hdr_move = 1'b1;
               rd_in = rd_ff + REC_W'(1);
               kept_in = kept_ff + REC_W'(1);
               state_in = ST_CREC;
            end else begin
               state_in = ST_CSRC;
            end
         end
         // walk: address the next word for the registered source read
         ST_WALK: begin
            state_in = ST_WRD;
         end
         // walk: sum the word, or load it once the output register is free
         ST_WRD: begin
            if (!pass_ff || !ovalid_ff || rsp_ready) begin
               cs_add = !pass_ff;
               load = pass_ff;
               state_in = ST_WALK;
               if (w_last) begin
                  ph_in = PH_HDR0;
                  rd_in = '0;
                  sj_in = '0;
                  if (pass_ff) begin
                     drop_in = 1'b0;
                     state_in = ST_OUT;
                  end else begin
                     pass_in = 1'b1;
                  end
               end else begin
                  unique case (ph_ff)
                     PH_HDR0: ph_in = PH_HDR1;
                     PH_HDR1: begin
                        ph_in = PH_REC;
                        rd_in = '0;
                     end
                     PH_REC: ph_in = PH_GRP;
                     PH_GRP: begin
                        sj_in = '0;
                        if (stot_ff[rd_e] == '0) begin
                           ph_in = PH_REC;
                           rd_in = rd_ff + REC_W'(1);
                        end else begin
                           ph_in = PH_SRC;
                        end
                     end
                     default: begin
                        if (sj_ff + CNT_W'(1) == stot_ff[rd_e]) begin
                           ph_in = PH_REC;
                           rd_in = rd_ff + REC_W'(1);
                           sj_in = '0;
                        end else begin
                           sj_in = sj_ff + CNT_W'(1);
                        end
                     end
                  endcase
               end
            end
         end
         // hold off new requests until the last word is taken
         ST_OUT: begin
            if (!ovalid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   igmp_rb_csum u_csum (
      .clock (clock),
      .clear (cs_clear),
      .add   (cs_add),
      .word  (w_word),
      .sum   (csum)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         newest_ff <= '0;
         open_ff   <= 1'b0;
         drop_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         newest_ff <= newest_in;
         open_ff   <= open_in;
         drop_ff   <= drop_in;
         if (load) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
      end
   end

   // datapath registers and table entries
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         grp_ff  <= req_group_address;
         src_ff  <= req_source_address;
         mode_ff <= req_record_mode;
         rc_ff   <= req_retransmit_count;
      end
      rd_ff   <= rd_in;
      kept_ff <= kept_in;
      sj_ff   <= sj_in;
      ph_ff   <= ph_in;
      pass_ff <= pass_in;
      if (load) begin
         word_ff  <= w_word;
         last_ff  <= w_last;
         odrop_ff <= drop_ff;
      end
      if (ent_new) begin
         excl_ff[used_e]  <= mode_ff;
         group_ff[used_e] <= grp_ff;
         count_ff[used_e] <= rc_ff;
         stot_ff[used_e]  <= '0;
      end
      if (src_add)
         stot_ff[newest_ff] <= stot_ff[newest_ff] + CNT_W'(1);
      if (hdr_move) begin
         excl_ff[kept_e]  <= excl_ff[rd_e];
         group_ff[kept_e] <= group_ff[rd_e];
         stot_ff[kept_e]  <= stot_ff[rd_e];
         count_ff[kept_e] <= count_ff[rd_e] - 4'd1;
      end
   end

   // source memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_packet_word = word_ff;
   assign rsp_last_word   = last_ff;
   assign rsp_dropped     = odrop_ff;

`ifndef NO_ASSERTIONS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while report pending");
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff & (valid_ff + 1'b1)) == '0)) else $error("table not a prefix");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_word) &&
      $stable(rsp_last_word) && $stable(rsp_dropped))
      else $error("stalled word changed");
`endif
endmodule
